// ===== rtl/sbde_pkg.sv =====
package sbde_pkg;

    // Default sizing of the bag store
    localparam int DEF_MAX_ITEMS = 128;
    localparam int DEF_NUM_BAGS  = 7;

    // Fixed field widths
    localparam int BAG_W   = 3;
    localparam int RND_W   = 31;
    localparam int ITEM_W  = 7;
    localparam int SIZE_RW = 8;
    localparam int CALC_W  = 9;

    // Size registers and their reset values
    localparam int CFG_REGS = 7;
    localparam logic [SIZE_RW-1:0] SIZE_RESET [CFG_REGS] = '{
        8'd119, 8'd78, 8'd98, 8'd3, 8'd15, 8'd6, 8'd3
    };

    // Access request to the order memory
    typedef struct packed {
        logic rd;
        logic wr;
    } ram_op_t;

endpackage

// ===== rtl/sbde_mod_serial.sv =====
module sbde_mod_serial #(
    parameter int DIV_W = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sbde_pkg::RND_W-1:0]    dividend,
    input  logic [DIV_W-1:0]              divisor,
    output logic                          done,
    output logic [DIV_W-1:0]              remainder
);
    import sbde_pkg::*;

    localparam int CNT_W = $clog2(RND_W + 1);

    logic [RND_W-1:0] num_reg;
    logic [DIV_W-1:0] div_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W-1:0] rem_next;

    // Shift one dividend bit into the partial remainder, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, num_reg[RND_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = DIV_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[DIV_W-1:0];
        end
    end

    // Load on start, then one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(RND_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= {num_reg[RND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/sbde_order_ram.sv =====
module sbde_order_ram #(
    parameter int MAX_ITEMS = sbde_pkg::DEF_MAX_ITEMS,
    parameter int NUM_BAGS  = sbde_pkg::DEF_NUM_BAGS,
    parameter int ENTRY_W   = $clog2(MAX_ITEMS),
    parameter int ADDR_W    = $clog2(MAX_ITEMS * NUM_BAGS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbde_pkg::ram_op_t     op,
    input  logic [ADDR_W-1:0]     rd_addr_a,
    input  logic [ADDR_W-1:0]     rd_addr_b,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [ENTRY_W-1:0]    wr_data,
    output logic [ENTRY_W-1:0]    rd_data_a,
    output logic [ENTRY_W-1:0]    rd_data_b,
    output logic                  clearing
);
    import sbde_pkg::*;

    localparam int DEPTH = MAX_ITEMS * NUM_BAGS;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_a_reg;
    logic [ENTRY_W-1:0] rd_b_reg;
    logic               clearing_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [ENTRY_W-1:0] clr_item_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    // Sweep owns the write port until every row holds identity
    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = clr_item_reg;
        end
        else
        begin
            mem_we    = op.wr;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    // Advance the identity sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            clr_item_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_item_reg == ENTRY_W'(MAX_ITEMS - 1))
                begin
                    clr_item_reg <= '0;
                end
                else
                begin
                    clr_item_reg <= clr_item_reg + 1'b1;
                end
            end
        end
    end

    // One write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (op.rd)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;
    assign clearing  = clearing_reg;

endmodule

// ===== rtl/shuffle_bag_draw_engine.sv =====
// Flow: one draw at a time. An accepted word passes through a prepare step, the
// remainder unit that takes one bit of the 31-bit random value per cycle, a read step,
// a swap write of the drawn slot, a swap write of the last slot and the result step; an
// unknown bag goes straight to the result step. A result word still held by the sink
// stalls the draw in its last step.
// Reset: asynchronous, active low. Afterwards the order memory is swept to identity,
// one entry per cycle over all NUM_BAGS * MAX_ITEMS entries (896 by default); no input
// word is taken during the sweep, configuration writes are.
module shuffle_bag_draw_engine #(
    parameter int MAX_ITEMS = sbde_pkg::DEF_MAX_ITEMS,
    parameter int NUM_BAGS  = sbde_pkg::DEF_NUM_BAGS
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] random_value, [31] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] bag_select
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] item_index, [7] zero
    output logic        m_axis_tuser    // [0] bad_bag
);
    import sbde_pkg::*;

    localparam int SIZE_W    = $clog2(MAX_ITEMS + 1);
    localparam int ENTRY_W   = $clog2(MAX_ITEMS);
    localparam int DEPTH     = MAX_ITEMS * NUM_BAGS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int BAG_IDX_W = (NUM_BAGS > 1) ? $clog2(NUM_BAGS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_READ,
        S_WPOS,
        S_WLAST,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [BAG_W-1:0]     bag_reg;
    logic [RND_W-1:0]     rnd_reg;
    logic                 bad_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic [ADDR_W-1:0]    pos_addr_reg;
    logic [ADDR_W-1:0]    last_addr_reg;
    logic [ENTRY_W-1:0]   picked_reg;
    logic                 out_valid_reg;
    logic [ITEM_W-1:0]    out_item_reg;
    logic                 out_bad_reg;
    logic [SIZE_RW-1:0]   size_reg [CFG_REGS];
    logic [SIZE_RW-1:0]   cnt_reg [NUM_BAGS];

    logic                 in_fire;
    logic                 bag_ok;
    logic [SIZE_RW-1:0]   raw_size;
    logic [CALC_W-1:0]    eff_size;
    logic [CALC_W-1:0]    cnt_cur;
    logic [CALC_W-1:0]    cnt_wrap;
    logic [CALC_W-1:0]    span;
    logic [CALC_W-1:0]    last_pos;
    logic [ADDR_W-1:0]    bag_base;
    logic                 div_start;
    logic                 div_done;
    logic [SIZE_W-1:0]    div_rem;
    ram_op_t              ram_op;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   rd_pos;
    logic [ENTRY_W-1:0]   rd_last;
    logic                 ram_clearing;
    logic                 out_free;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE) && !ram_clearing;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign bag_ok        = {1'b0, s_axis_tuser} < (BAG_W + 1)'(NUM_BAGS);
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Hold the bag sizes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_REGS; i++)
            begin
                size_reg[i] <= SIZE_RESET[i];
            end
        end
        else if (cfg_valid && cfg_ready && (cfg_index < 3'(CFG_REGS)))
        begin
            size_reg[cfg_index] <= cfg_data;
        end
    end

    // Clamp the size, wrap a spent count, derive divisor and last position
    always_comb
    begin
        if (bag_reg < BAG_W'(CFG_REGS))
        begin
            raw_size = size_reg[bag_reg];
        end
        else
        begin
            raw_size = '1;
        end
        eff_size = {1'b0, raw_size};
        if (eff_size == '0)
        begin
            eff_size = CALC_W'(1);
        end
        if ((bag_reg >= BAG_W'(CFG_REGS)) || (eff_size > CALC_W'(MAX_ITEMS)))
        begin
            eff_size = CALC_W'(MAX_ITEMS);
        end
        cnt_cur  = {1'b0, cnt_reg[bag_reg[BAG_IDX_W-1:0]]};
        cnt_wrap = (cnt_cur >= eff_size) ? '0 : cnt_cur;
        span     = eff_size - cnt_wrap;
        last_pos = span - CALC_W'(1);
        bag_base = ADDR_W'(bag_reg) * ADDR_W'(MAX_ITEMS);
    end

    // Start the remainder unit when the divisor is ready
    assign div_start = (state_reg == S_PREP);

    sbde_mod_serial #(
        .DIV_W (SIZE_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rnd_reg),
        .divisor   (SIZE_W'(span)),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Drive the memory: read both slots, then swap them
    always_comb
    begin
        ram_op.rd = (state_reg == S_READ);
        ram_op.wr = (state_reg == S_WPOS) || (state_reg == S_WLAST);
        if (state_reg == S_WPOS)
        begin
            ram_waddr = pos_addr_reg;
            ram_wdata = rd_last;
        end
        else
        begin
            ram_waddr = last_addr_reg;
            ram_wdata = picked_reg;
        end
    end

    sbde_order_ram #(
        .MAX_ITEMS (MAX_ITEMS),
        .NUM_BAGS  (NUM_BAGS),
        .ENTRY_W   (ENTRY_W),
        .ADDR_W    (ADDR_W)
    ) u_ram (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (ram_op),
        .rd_addr_a (pos_addr_reg),
        .rd_addr_b (last_addr_reg),
        .wr_addr   (ram_waddr),
        .wr_data   (ram_wdata),
        .rd_data_a (rd_pos),
        .rd_data_b (rd_last),
        .clearing  (ram_clearing)
    );

    // Sequence one draw and hold its result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < NUM_BAGS; b++)
            begin
                cnt_reg[b] <= '0;
            end
        end
        else
        begin
            // Drop a taken word unless a new one replaces it
            if (m_axis_tready && !((state_reg == S_DONE) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        bag_reg   <= s_axis_tuser;
                        rnd_reg   <= s_axis_tdata[RND_W-1:0];
                        bad_reg   <= !bag_ok;
                        state_reg <= bag_ok ? S_PREP : S_DONE;
                    end
                end
                S_PREP:
                begin
                    cnt_reg[bag_reg[BAG_IDX_W-1:0]] <= SIZE_RW'(cnt_wrap + CALC_W'(1));
                    base_reg      <= bag_base;
                    last_addr_reg <= bag_base + ADDR_W'(last_pos);
                    state_reg     <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        pos_addr_reg <= base_reg + ADDR_W'(div_rem);
                        state_reg    <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_WPOS;
                end
                S_WPOS:
                begin
                    picked_reg <= rd_pos;
                    state_reg  <= S_WLAST;
                end
                S_WLAST:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_item_reg  <= bad_reg ? '0 : ITEM_W'(picked_reg);
                        out_bad_reg   <= bad_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_item_reg};
    assign m_axis_tuser  = out_bad_reg;

    // No request is taken while the memory is still being swept
    a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !ram_clearing)
        else $error("request taken during memory sweep");

    // The divisor is never zero for a valid bag
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREP) |-> (span != '0))
        else $error("zero divisor");

    // The remainder unit finishes only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("remainder done outside wait state");

    // The drawn slot never lies past the swap slot
    a_pos_before_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (pos_addr_reg <= last_addr_reg))
        else $error("draw position beyond last slot");

endmodule
